// File: rtl/core/wsfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants of the websocket frame deframer: parser phases,
// opcodes, result kinds, length codes and the result word layout.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HEAD0 = 3'd0,
        PH_HEAD1 = 3'd1,
        PH_EXT   = 3'd2,
        PH_KEY   = 3'd3,
        PH_DATA  = 3'd4
    } phase_t;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;

    localparam logic [1:0] KIND_TEXT   = 2'd0;
    localparam logic [1:0] KIND_BINARY = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;
    localparam logic [1:0] KIND_PING   = 2'd3;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;

    localparam logic [2:0] EXT_LEFT_16 = 3'd1;
    localparam logic [2:0] EXT_LEFT_64 = 3'd7;

    localparam logic [1:0] KEY_IDX_LAST = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [1:0] kind;
        logic       has_byte;
        logic       frame_end;
    } wsfd_res_t;

endpackage
`default_nettype wire

// File: rtl/core/wsfd_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_parse
// Frame header parser and payload unmasker. Consumes one registered word per
// step and produces at most one result word combinationally.
// ----------------------------------------------------------------------------
module wsfd_parse #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         byte_in,
    output wsfd_pkg::wsfd_res_t     res
);
    import wsfd_pkg::*;

    phase_t                  phase_reg,  phase_next;
    logic [3:0]              opcode_reg, opcode_next;
    logic                    masked_reg, masked_next;
    logic [2:0]              ext_cnt_reg, ext_cnt_next;
    logic [LENGTH_BITS-1:0]  len_reg,    len_next;
    logic                    ovf_reg,    ovf_next;
    logic [31:0]             key_reg,    key_next;
    logic [1:0]              kidx_reg,   kidx_next;

    logic [6:0]              code;
    logic [LENGTH_BITS-1:0]  ext_shift;
    logic                    ext_ovf;
    logic [LENGTH_BITS-1:0]  ext_sat;
    logic                    len_fire;
    logic [LENGTH_BITS-1:0]  len_val;
    logic                    len_masked;
    logic                    hd_fire;
    logic [LENGTH_BITS-1:0]  hd_len;
    logic                    hd_empty;
    logic                    data_last;
    logic                    is_data;
    logic                    is_ctrl;
    logic [1:0]              kind;
    logic [7:0]              key_byte;

    // header decode helpers
    always_comb
    begin
        code       = byte_in[6:0];
        ext_shift  = {len_reg[LENGTH_BITS-9:0], byte_in};
        ext_ovf    = ovf_reg | (len_reg[LENGTH_BITS-1 -: 8] != 8'd0);
        ext_sat    = ext_ovf ? {LENGTH_BITS{1'b1}} : ext_shift;
        len_fire   = ((phase_reg == PH_HEAD1) && (code != LEN_CODE_16)
                      && (code != LEN_CODE_64))
                     || ((phase_reg == PH_EXT) && (ext_cnt_reg == 3'd0));
        len_val    = (phase_reg == PH_HEAD1) ? LENGTH_BITS'(code) : ext_sat;
        len_masked = (phase_reg == PH_HEAD1) ? byte_in[7] : masked_reg;
        hd_fire    = (len_fire && !len_masked)
                     || ((phase_reg == PH_KEY) && (kidx_reg == KEY_IDX_LAST));
        hd_len     = (phase_reg == PH_KEY) ? len_reg : len_val;
        hd_empty   = (hd_len == '0);
        data_last  = (len_reg == LENGTH_BITS'(1));
        is_data    = (opcode_reg == OP_TEXT) || (opcode_reg == OP_BINARY);
        is_ctrl    = (opcode_reg == OP_CLOSE) || (opcode_reg == OP_PING);
        case (opcode_reg)
            OP_TEXT:   kind = KIND_TEXT;
            OP_BINARY: kind = KIND_BINARY;
            OP_CLOSE:  kind = KIND_CLOSE;
            default:   kind = KIND_PING;
        endcase
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        ext_cnt_next = ext_cnt_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        key_next     = key_reg;
        kidx_next    = kidx_reg;
        unique case (phase_reg)
            PH_HEAD1:
            begin
                masked_next = byte_in[7];
                ovf_next    = 1'b0;
                len_next    = '0;
                if (code == LEN_CODE_16)
                begin
                    ext_cnt_next = EXT_LEFT_16;
                    phase_next   = PH_EXT;
                end
                else if (code == LEN_CODE_64)
                begin
                    ext_cnt_next = EXT_LEFT_64;
                    phase_next   = PH_EXT;
                end
            end
            PH_EXT:
            begin
                if (ext_cnt_reg != 3'd0)
                begin
                    len_next     = ext_shift;
                    ovf_next     = ext_ovf;
                    ext_cnt_next = ext_cnt_reg - 3'd1;
                end
            end
            PH_KEY:
            begin
                key_next  = {key_reg[23:0], byte_in};
                kidx_next = kidx_reg + 2'd1;
            end
            PH_DATA:
            begin
                kidx_next = kidx_reg + 2'd1;
                len_next  = len_reg - LENGTH_BITS'(1);
                if (data_last)
                begin
                    phase_next = PH_HEAD0;
                end
            end
            default:
            begin
                opcode_next  = byte_in[3:0];
                masked_next  = 1'b0;
                ext_cnt_next = 3'd0;
                len_next     = '0;
                kidx_next    = 2'd0;
                phase_next   = PH_HEAD1;
            end
        endcase
        // length complete: key follows when masked
        if (len_fire && len_masked)
        begin
            phase_next = PH_KEY;
            kidx_next  = 2'd0;
            key_next   = '0;
            len_next   = len_val;
        end
        // header complete
        if (hd_fire)
        begin
            kidx_next  = 2'd0;
            len_next   = hd_len;
            phase_next = hd_empty ? PH_HEAD0 : PH_DATA;
        end
    end

    // result word
    always_comb
    begin
        res           = '0;
        res.kind      = kind;
        unique case (phase_reg)
            PH_HEAD1, PH_EXT, PH_KEY:
            begin
                if (hd_fire && hd_empty && is_ctrl)
                begin
                    res.valid     = 1'b1;
                    res.frame_end = 1'b1;
                end
            end
            PH_DATA:
            begin
                if (is_data)
                begin
                    res.valid     = 1'b1;
                    res.has_byte  = 1'b1;
                    res.data      = byte_in ^ (masked_reg ? key_byte : 8'd0);
                    res.frame_end = data_last;
                end
                else if (is_ctrl && data_last)
                begin
                    res.valid     = 1'b1;
                    res.frame_end = 1'b1;
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD0;
            opcode_reg  <= 4'd0;
            masked_reg  <= 1'b0;
            ext_cnt_reg <= 3'd0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            key_reg     <= '0;
            kidx_reg    <= 2'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            ext_cnt_reg <= ext_cnt_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            key_reg     <= key_next;
            kidx_reg    <= kidx_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/websocket_frame_deframer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side websocket frame parser: header decode, extended length,
// mask key capture and payload unmasking; one stream word per clock unless out_ready stalls.
// ----------------------------------------------------------------------------
// Takes one received word per clock and returns at most one result word per
// input word; throughput is one word per clock as long as out_ready is held
// high. A word is first captured in the input register; the header and
// payload logic then loads its result, if any, into the output register,
// and out_valid rises, once that register is free or being taken. Payload
// lengths wider than LENGTH_BITS saturate.
module websocket_frame_deframer_core #(
    parameter int LENGTH_BITS = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire logic [7:0] rx_byte,
    output      logic       out_valid,
    input  wire logic       out_ready,
    output      logic [7:0] out_byte,
    output      logic [1:0] frame_kind,
    output      logic       has_byte,
    output      logic       frame_end
);
    import wsfd_pkg::*;

    logic       in_vld_reg,  in_vld_next;
    logic [7:0] in_byte_reg;
    logic       out_vld_reg, out_vld_next;
    wsfd_res_t  out_res_reg;
    wsfd_res_t  res;
    logic       advance;

    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    always_comb
    begin
        in_vld_next  = in_ready ? in_valid : in_vld_reg;
        out_vld_next = advance ? res.valid : (out_vld_reg && !out_ready);
    end

    wsfd_parse #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && res.valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_byte   = out_res_reg.data;
    assign frame_kind = out_res_reg.kind;
    assign has_byte   = out_res_reg.has_byte;
    assign frame_end  = out_res_reg.frame_end;

endmodule
`default_nettype wire

// File: rtl/core/wsfd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks of the websocket frame deframer result channel, bound
// to the top level.
// ----------------------------------------------------------------------------
module wsfd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [1:0] frame_kind,
    input wire logic       has_byte,
    input wire logic       frame_end
);
    import wsfd_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(frame_kind)
            && $stable(has_byte) && $stable(frame_end))
        else $error("result word changed while stalled");

    // payload words only for text and binary frames
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_byte |-> frame_kind == KIND_TEXT || frame_kind == KIND_BINARY)
        else $error("payload word with control kind");

    // control events are a bare frame end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> frame_end && out_byte == 8'd0)
        else $error("event word malformed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_kind == KIND_CLOSE || frame_kind == KIND_PING) |-> !has_byte)
        else $error("control frame carried a payload word");

endmodule

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .frame_kind (frame_kind),
    .has_byte   (has_byte),
    .frame_end  (frame_end)
);
`default_nettype wire
